/* src/mae_pkg.sv */
// ----------------------------------------------------------------------------
// mae_pkg
// Shared constants, types and sequencer states for the minimum arborescence
// engine.
// ----------------------------------------------------------------------------
package mae_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int MAX_EDGES    = 16384;

    // vertex numbers and labels, with room for a count one past the last vertex
    localparam int VIDX_W  = $clog2(MAX_VERTICES + 2);
    localparam int VDEPTH  = MAX_VERTICES + 1;
    // vertex field of an edge word: wide enough for raw 8-bit endpoints
    localparam int VW      = (VIDX_W > 8) ? VIDX_W : 8;
    localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int WT_W    = 24;
    localparam int TOT_W   = 32;

    typedef struct packed {
        logic            last;
        logic [WT_W-1:0] cost;
        logic [7:0]      to;
        logic [7:0]      from;
    } t_edge;

    typedef struct packed {
        logic             status;
        logic [TOT_W-1:0] total;
    } t_result;

    typedef struct packed {
        logic [WT_W-1:0] wt;
        logic [VW-1:0]   dst;
        logic [VW-1:0]   src;
    } t_wk;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_FILT_RD, S_FILT_WR, S_RND, S_MIN_RD, S_MIN_CW,
        S_MIN_UPD, S_CHK, S_W_START, S_W_ADD, S_W_RD, S_W_TST, S_C_RD,
        S_C_WR, S_W_DONE, S_L_RD, S_L_WR, S_X_RD, S_X_LU, S_X_LV, S_X_WR,
        S_X_RT, S_DONE
    } t_state;

    localparam logic [7:0] CFG_VCOUNT = 8'd0;
    localparam logic [7:0] CFG_ROOT   = 8'd1;

endpackage

/* src/mae_core.sv */
// ----------------------------------------------------------------------------
// mae_core
// Edge store, per-vertex memories and the round sequencer: cheapest incoming
// edge, cycle walk, relabel and contraction.
// ----------------------------------------------------------------------------
module mae_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_vcount,
    input  logic [7:0]       i_root,
    input  logic             i_load,
    input  mae_pkg::t_edge   i_edge,
    output logic             o_ready,
    output logic             o_done,
    output mae_pkg::t_result o_result,
    input  logic             i_take
);
    import mae_pkg::*;

    t_state r_state, n_state;

    logic [ECNT_W-1:0] r_cnt, n_cnt, r_e, n_e, r_m, n_m;
    logic [VIDX_W-1:0] r_n, n_n, r_rt, n_rt, r_i, n_i, r_k, n_k;
    logic [VIDX_W-1:0] r_cur, n_cur, r_p, n_p, r_u, n_u, r_v, n_v, r_lu, n_lu;
    logic [WT_W-1:0]   r_w, n_w;
    logic [TOT_W-1:0]  r_res, n_res;
    logic              r_fail, n_fail;
    logic [VDEPTH-1:0] r_cvalid, n_cvalid;

    // edge working store
    t_wk               wk_mem [MAX_EDGES];
    t_wk               r_wk_rd, wk_wd;
    logic              wk_we;
    logic [EIDX_W-1:0] wk_wa, wk_ra;

    // per-vertex stores
    logic [WT_W-1:0]   cw_mem   [VDEPTH];
    logic [VIDX_W-1:0] par_mem  [VDEPTH];
    logic [VIDX_W-1:0] lab_mem  [VDEPTH];
    logic [VIDX_W-1:0] mark_mem [VDEPTH];
    logic [WT_W-1:0]   r_cw_rd, cw_wd;
    logic [VIDX_W-1:0] r_par_rd, r_lab_rd, r_mark_rd, par_wd, lab_wd, mark_wd;
    logic              cw_we, lab_we, mark_we;
    logic [VIDX_W-1:0] va, vwa;

    logic              bad_cfg, in_rng;
    logic [TOT_W:0]    sum;
    logic [VIDX_W-1:0] k1;

    always_ff @(posedge i_clk) begin
        if (wk_we) begin
            wk_mem[wk_wa] <= wk_wd;
        end
        r_wk_rd <= wk_mem[wk_ra];
        if (cw_we) begin
            cw_mem[vwa]  <= cw_wd;
            par_mem[vwa] <= par_wd;
        end
        if (lab_we) begin
            lab_mem[vwa] <= lab_wd;
        end
        if (mark_we) begin
            mark_mem[vwa] <= mark_wd;
        end
        r_cw_rd   <= cw_mem[va];
        r_par_rd  <= par_mem[va];
        r_lab_rd  <= lab_mem[va];
        r_mark_rd <= mark_mem[va];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_fail   <= 1'b0;
            r_cvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_fail   <= n_fail;
            r_cvalid <= n_cvalid;
        end
        r_e   <= n_e;
        r_m   <= n_m;
        r_n   <= n_n;
        r_rt  <= n_rt;
        r_i   <= n_i;
        r_k   <= n_k;
        r_cur <= n_cur;
        r_p   <= n_p;
        r_u   <= n_u;
        r_v   <= n_v;
        r_lu  <= n_lu;
        r_w   <= n_w;
        r_res <= n_res;
    end

    assign bad_cfg = (i_vcount == 8'd0) || ({1'b0, i_vcount} > 9'(MAX_VERTICES))
                  || (i_root == 8'd0) || (i_root > i_vcount);
    assign in_rng  = (r_wk_rd.src != '0) && (r_wk_rd.src <= VW'(r_n))
                  && (r_wk_rd.dst != '0) && (r_wk_rd.dst <= VW'(r_n));
    assign sum     = {1'b0, r_res} + (TOT_W+1)'(r_cw_rd);
    assign k1      = r_k + 1'b1;

    assign o_ready         = (r_state == S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_result.status = r_fail;
    assign o_result.total  = r_fail ? '0 : r_res;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_e      = r_e;
        n_m      = r_m;
        n_n      = r_n;
        n_rt     = r_rt;
        n_i      = r_i;
        n_k      = r_k;
        n_cur    = r_cur;
        n_p      = r_p;
        n_u      = r_u;
        n_v      = r_v;
        n_lu     = r_lu;
        n_w      = r_w;
        n_res    = r_res;
        n_fail   = r_fail;
        n_cvalid = r_cvalid;
        wk_we    = 1'b0;
        wk_wa    = r_m[EIDX_W-1:0];
        wk_wd    = r_wk_rd;
        wk_ra    = r_e[EIDX_W-1:0];
        cw_we    = 1'b0;
        lab_we   = 1'b0;
        mark_we  = 1'b0;
        cw_wd    = r_w;
        par_wd   = r_u;
        lab_wd   = '0;
        mark_wd  = '0;
        va       = r_i;
        vwa      = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (i_load) begin
                    if (r_cnt < ECNT_W'(MAX_EDGES)) begin
                        wk_we     = 1'b1;
                        wk_wa     = r_cnt[EIDX_W-1:0];
                        wk_wd.src = VW'(i_edge.from);
                        wk_wd.dst = VW'(i_edge.to);
                        wk_wd.wt  = i_edge.cost;
                        n_cnt     = r_cnt + 1'b1;
                    end
                    if (i_edge.last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_fail = 1'b0;
                n_e    = '0;
                n_m    = '0;
                n_res  = '0;
                n_n    = VIDX_W'(i_vcount);
                n_rt   = VIDX_W'(i_root);
                if (bad_cfg) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FILT_RD;
                end
            end
            // compact in-range edges in place; the write pointer never passes the read
            S_FILT_RD: begin
                n_state = (r_e == r_cnt) ? S_RND : S_FILT_WR;
            end
            S_FILT_WR: begin
                wk_we = 1'b1;
                if (in_rng) begin
                    n_m = r_m + 1'b1;
                end
                n_e     = r_e + 1'b1;
                n_state = S_FILT_RD;
            end
            S_RND: begin
                n_cvalid = '0;
                n_e      = '0;
                n_state  = S_MIN_RD;
            end
            S_MIN_RD: begin
                if (r_e == r_m) begin
                    n_i     = VIDX_W'(1);
                    n_state = S_CHK;
                end else begin
                    n_state = S_MIN_CW;
                end
            end
            S_MIN_CW: begin
                n_u     = VIDX_W'(r_wk_rd.src);
                n_v     = VIDX_W'(r_wk_rd.dst);
                n_w     = r_wk_rd.wt;
                va      = VIDX_W'(r_wk_rd.dst);
                n_state = S_MIN_UPD;
            end
            S_MIN_UPD: begin
                vwa = r_v;
                if (r_u != r_v && (!r_cvalid[r_v] || r_cw_rd > r_w)) begin
                    cw_we          = 1'b1;
                    n_cvalid[r_v]  = 1'b1;
                end
                n_e     = r_e + 1'b1;
                n_state = S_MIN_RD;
            end
            // check coverage and clear walk marks and labels together
            S_CHK: begin
                if (r_i > r_n) begin
                    n_i     = VIDX_W'(1);
                    n_k     = '0;
                    n_state = S_W_START;
                end else begin
                    mark_we = 1'b1;
                    lab_we  = 1'b1;
                    n_i     = r_i + 1'b1;
                    if (r_i != r_rt && !r_cvalid[r_i]) begin
                        n_fail  = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_W_START: begin
                n_cur = r_i;
                if (r_i > r_n) begin
                    n_state = S_W_DONE;
                end else if (r_i == r_rt) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_state = S_W_ADD;
                end
            end
            S_W_ADD: begin
                n_res   = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
                n_state = S_W_RD;
            end
            S_W_RD: begin
                va      = r_cur;
                n_state = S_W_TST;
            end
            S_W_TST: begin
                vwa = r_cur;
                if (r_mark_rd != r_i && r_lab_rd == '0 && r_cur != r_rt) begin
                    mark_we = 1'b1;
                    mark_wd = r_i;
                    n_cur   = r_par_rd;
                    n_state = S_W_RD;
                end else if (r_mark_rd == r_i) begin
                    n_k     = k1;
                    lab_we  = 1'b1;
                    lab_wd  = k1;
                    n_p     = r_par_rd;
                    n_state = S_C_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_W_START;
                end
            end
            S_C_RD: begin
                va = r_p;
                if (r_p == r_cur) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_W_START;
                end else begin
                    n_state = S_C_WR;
                end
            end
            S_C_WR: begin
                vwa     = r_p;
                lab_we  = 1'b1;
                lab_wd  = r_k;
                n_p     = r_par_rd;
                n_state = S_C_RD;
            end
            S_W_DONE: begin
                n_i     = VIDX_W'(1);
                n_state = (r_k == '0) ? S_DONE : S_L_RD;
            end
            S_L_RD: begin
                if (r_i > r_n) begin
                    n_e     = '0;
                    n_state = S_X_RD;
                end else begin
                    n_state = S_L_WR;
                end
            end
            S_L_WR: begin
                if (r_lab_rd == '0) begin
                    n_k    = k1;
                    lab_we = 1'b1;
                    lab_wd = k1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_L_RD;
            end
            S_X_RD: begin
                va      = r_rt;
                n_state = (r_e == r_m) ? S_X_RT : S_X_LU;
            end
            S_X_LU: begin
                n_u     = VIDX_W'(r_wk_rd.src);
                n_v     = VIDX_W'(r_wk_rd.dst);
                n_w     = r_wk_rd.wt;
                va      = VIDX_W'(r_wk_rd.src);
                n_state = S_X_LV;
            end
            S_X_LV: begin
                n_lu    = r_lab_rd;
                va      = r_v;
                n_state = S_X_WR;
            end
            S_X_WR: begin
                wk_we     = 1'b1;
                wk_wa     = r_e[EIDX_W-1:0];
                wk_wd.src = VW'(r_lu);
                wk_wd.dst = VW'(r_lab_rd);
                wk_wd.wt  = (r_lu != r_lab_rd && r_cvalid[r_v]) ? r_w - r_cw_rd : r_w;
                n_e       = r_e + 1'b1;
                n_state   = S_X_RD;
            end
            S_X_RT: begin
                n_rt    = r_lab_rd;
                n_n     = r_k;
                n_state = S_RND;
            end
            S_DONE: begin
                if (i_take) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/min_arborescence_engine.sv */
// ----------------------------------------------------------------------------
// min_arborescence_engine
// Minimum-weight arborescence of a directed graph, loaded edge by edge.
// ----------------------------------------------------------------------------
// Usage:
//   Write vertex_count (index 0) and root_vertex (index 1) on the cfg channel
//   while the engine is idle. Stream edges on s_axis, one beat per cycle;
//   tlast marks the final edge and starts the solve. Edges beyond the store
//   depth are dropped.
//   s_axis is stalled during the solve. After the last edge the engine
//   compacts the edge store to the in-range edges, then runs contraction
//   rounds: each round finds the cheapest incoming edge of every vertex,
//   checks that every vertex but the root has one, walks from each vertex
//   to find cycles, relabels and contracts the edges, until no cycle remains.
//   One beat on m_axis carries the total cost and the status flag. It sits in
//   an output register; edge loading for the next graph proceeds while it
//   waits, and a new solve finishing holds until the receiver takes the beat.
//   Reset returns both registers to 1, empties the edge store and drops any
//   pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module min_arborescence_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // edge_from[7:0], edge_to[15:8], edge_cost[39:16]
    input  logic        s_axis_tlast,   // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // total_cost[31:0]
    output logic        m_axis_tuser    // status
);
    import mae_pkg::*;

    logic [7:0]  r_vcount, r_root;
    logic        r_ovalid;
    t_result     r_out;
    t_edge       edge_in;
    t_result     result;
    logic        core_ready, core_done, take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 8'd1;
            r_root   <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_VCOUNT: r_vcount <= i_cfg_data;
                CFG_ROOT:   r_root   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign edge_in.from = s_axis_tdata[7:0];
    assign edge_in.to   = s_axis_tdata[15:8];
    assign edge_in.cost = s_axis_tdata[39:16];
    assign edge_in.last = s_axis_tlast;

    assign s_axis_tready = core_ready;
    assign take          = !r_ovalid || m_axis_tready;

    mae_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vcount (r_vcount),
        .i_root   (r_root),
        .i_load   (s_axis_tvalid && core_ready),
        .i_edge   (edge_in),
        .o_ready  (core_ready),
        .o_done   (core_done),
        .o_result (result),
        .i_take   (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= core_done;
        end
        if (take && core_done) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out.total;
    assign m_axis_tuser  = r_out.status;

endmodule
